// ----- rtl/core/tptc_pkg.sv -----
// ============================================================================
// tptc_pkg
// shared types, constants and the solve microprogram for the touch calibrator
// ============================================================================
package tptc_pkg;

   localparam int NUM_OPS     = 33;
   localparam int NUM_COEF    = 6;
   localparam int COEF_W      = 32;
   localparam int SCALE_W     = 16;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10000;

   typedef enum logic [2:0] {
      A_X1, A_X2, A_X3, A_W1, A_W2, A_W3, A_SCALE
   } asel_type;

   typedef enum logic [3:0] {
      B_DY23, B_DY13, B_DY12, B_DX32, B_DX13, B_DX21,
      B_Y1, B_Y2, B_Y3, B_CR1, B_CR2, B_CR3, B_ACC
   } bsel_type;

   typedef enum logic [2:0] {
      D_NONE, D_CR1, D_CR2, D_CR3, D_DET, D_NUM
   } dest_type;

   typedef struct packed {
      asel_type a;
      bsel_type b;
      logic     first;
      logic     neg;
      logic     use_y;
      dest_type dest;
   } op_type;

   // multiply-accumulate program: determinant, cross terms, then six numerators
   localparam op_type OP_PROG [NUM_OPS] = '{
      '{A_X1, B_DY23, 1'b1, 1'b0, 1'b0, D_NONE},
      '{A_X2, B_DY13, 1'b0, 1'b1, 1'b0, D_NONE},
      '{A_X3, B_DY12, 1'b0, 1'b0, 1'b0, D_DET},
      '{A_X2, B_Y3,   1'b1, 1'b0, 1'b0, D_NONE},
      '{A_X3, B_Y2,   1'b0, 1'b1, 1'b0, D_CR1},
      '{A_X1, B_Y3,   1'b1, 1'b0, 1'b0, D_NONE},
      '{A_X3, B_Y1,   1'b0, 1'b1, 1'b0, D_CR2},
      '{A_X1, B_Y2,   1'b1, 1'b0, 1'b0, D_NONE},
      '{A_X2, B_Y1,   1'b0, 1'b1, 1'b0, D_CR3},
      '{A_W1, B_DY23, 1'b1, 1'b0, 1'b0, D_NONE},
      '{A_W2, B_DY13, 1'b0, 1'b1, 1'b0, D_NONE},
      '{A_W3, B_DY12, 1'b0, 1'b0, 1'b0, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b0, D_NUM},
      '{A_W1, B_DX32, 1'b1, 1'b0, 1'b0, D_NONE},
      '{A_W2, B_DX13, 1'b0, 1'b0, 1'b0, D_NONE},
      '{A_W3, B_DX21, 1'b0, 1'b0, 1'b0, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b0, D_NUM},
      '{A_W1, B_CR1,  1'b1, 1'b0, 1'b0, D_NONE},
      '{A_W2, B_CR2,  1'b0, 1'b1, 1'b0, D_NONE},
      '{A_W3, B_CR3,  1'b0, 1'b0, 1'b0, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b0, D_NUM},
      '{A_W1, B_DY23, 1'b1, 1'b0, 1'b1, D_NONE},
      '{A_W2, B_DY13, 1'b0, 1'b1, 1'b1, D_NONE},
      '{A_W3, B_DY12, 1'b0, 1'b0, 1'b1, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b1, D_NUM},
      '{A_W1, B_DX32, 1'b1, 1'b0, 1'b1, D_NONE},
      '{A_W2, B_DX13, 1'b0, 1'b0, 1'b1, D_NONE},
      '{A_W3, B_DX21, 1'b0, 1'b0, 1'b1, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b1, D_NUM},
      '{A_W1, B_CR1,  1'b1, 1'b0, 1'b1, D_NONE},
      '{A_W2, B_CR2,  1'b0, 1'b1, 1'b1, D_NONE},
      '{A_W3, B_CR3,  1'b0, 1'b0, 1'b1, D_NONE},
      '{A_SCALE, B_ACC, 1'b1, 1'b0, 1'b1, D_NUM}
   };

   typedef struct packed {
      logic       load_point;
      logic [1:0] pt_idx;
      logic       calc_diff;
      logic       mul_en;
      logic       acc_en;
      op_type     op;
      logic       div_step;
      logic       wb;
      logic [2:0] coef_idx;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic det_zero;
      logic div_last;
   } dp_stat_type;

endpackage

// ----- rtl/core/three_point_touch_calibration.sv -----
// ============================================================================
// three_point_touch_calibration
// three-point affine touchscreen calibration, exact solve by cramer's rule
//
// channel   dir  beat contents
// req_*     in   one calibration point: touch_x, touch_y, pixel_x, pixel_y
// rsp_*     out  coef_a..coef_f, scale_out in tdata; solvable in tuser
// csr_*     in   coef_scale write, no read-back
//
// points one and two are only stored. the third point starts a solve: the
// difference terms, the multiply-accumulate program and, per coefficient, a
// PW-bit divide, PW = SCREEN_BITS + 2*TOUCH_BITS + 19, on the one-bit-per-cycle divider.
// a collinear set skips the divides. after reset the point count is zero and
// coef_scale is 10000. a third point waits while the previous result beat
// has not been taken.
// ============================================================================
module three_point_touch_calibration #(
   parameter int TOUCH_BITS  = 12,
   parameter int SCREEN_BITS = 11
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // touch_x, touch_y, pixel_x, pixel_y, zero fill
   input  logic [((2*TOUCH_BITS+2*SCREEN_BITS+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, scale_out
   output logic [6*32+16-1:0] rsp_tdata,
   // solvable
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import tptc_pkg::*;

   localparam int T = TOUCH_BITS;
   localparam int S = SCREEN_BITS;

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [COEF_W-1:0]   coef [NUM_COEF];
   logic [SCALE_W-1:0]  scale_out;
   logic                solvable;

   tptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tptc_dpath #(
      .TOUCH_BITS  (TOUCH_BITS),
      .SCREEN_BITS (SCREEN_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_tx       (req_tdata[T-1:0]),
      .in_ty       (req_tdata[2*T-1:T]),
      .in_sx       (req_tdata[2*T+S-1:2*T]),
      .in_sy       (req_tdata[2*T+2*S-1:2*T+S]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .coef        (coef),
      .scale_out   (scale_out),
      .solvable    (solvable)
   );

   assign rsp_tdata = {scale_out, coef[5], coef[4], coef[3], coef[2], coef[1], coef[0]};
   assign rsp_tuser = solvable;

`ifndef NO_ASSERTIONS
   a_collinear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("collinear result carries nonzero data");

   a_wb_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> $past(cmd.div_step))
      else $error("coefficient written without a preceding divide step");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.finish))
      else $error("result beat raised without finishing a solve");

   a_no_accept_in_solve: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_en || cmd.acc_en || cmd.div_step) |-> !req_tready)
      else $error("point accepted during a solve");
`endif

endmodule

// ----- rtl/core/tptc_ctrl.sv -----
// ============================================================================
// tptc_ctrl
// sequencer: point counting, microprogram stepping, divide and result beat
// ============================================================================
module tptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  tptc_pkg::dp_stat_type stat,
   output tptc_pkg::dp_cmd_type  cmd
);
   import tptc_pkg::*;

   localparam int PCW = $clog2(NUM_OPS);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIFF = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_ACC  = 8'b0000_1000,
      ST_CHK  = 8'b0001_0000,
      ST_DIV  = 8'b0010_0000,
      ST_WB   = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [1:0]     pts_ff, pts_in;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [2:0]     coef_ff, coef_in;
   logic           valid_ff, valid_in;
   logic           accept;

   assign req_tready = (state_ff == ST_IDLE) && ((pts_ff != 2'd2) || !valid_ff);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      pts_in       = pts_ff;
      pc_in        = pc_ff;
      coef_in      = coef_ff;
      valid_in     = valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.op       = OP_PROG[pc_ff];
      cmd.pt_idx   = pts_ff;
      cmd.coef_idx = coef_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_point = 1'b1;
               if (pts_ff == 2'd2) begin
                  pts_in   = 2'd0;
                  pc_in    = '0;
                  coef_in  = '0;
                  state_in = ST_DIFF;
               end else begin
                  pts_in = pts_ff + 2'd1;
               end
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (pc_ff != PCW'(NUM_OPS - 1)) begin
               pc_in = pc_ff + PCW'(1);
            end
            unique case (cmd.op.dest)
               D_DET:   state_in = ST_CHK;
               D_NUM:   state_in = ST_DIV;
               default: state_in = ST_MUL;
            endcase
         end
         ST_CHK: begin
            state_in = stat.det_zero ? ST_FIN : ST_MUL;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (coef_ff == 3'(NUM_COEF - 1)) begin
               state_in = ST_FIN;
            end else begin
               coef_in  = coef_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pts_ff   <= '0;
         pc_ff    <= '0;
         coef_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pts_ff   <= pts_in;
         pc_ff    <= pc_in;
         coef_ff  <= coef_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- rtl/core/tptc_dpath.sv -----
// ============================================================================
// tptc_dpath
// point store, shared multiply-accumulate, radix-2 divider, result registers
// ============================================================================
module tptc_dpath #(
   parameter int TOUCH_BITS  = 12,
   parameter int SCREEN_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tptc_pkg::dp_cmd_type                cmd,
   output tptc_pkg::dp_stat_type               stat,
   input  logic [TOUCH_BITS-1:0]               in_tx,
   input  logic [TOUCH_BITS-1:0]               in_ty,
   input  logic [SCREEN_BITS-1:0]              in_sx,
   input  logic [SCREEN_BITS-1:0]              in_sy,
   input  logic                                csr_wr_en,
   input  logic [tptc_pkg::SCALE_W-1:0]        csr_wr_data,
   output logic [tptc_pkg::COEF_W-1:0]         coef [tptc_pkg::NUM_COEF],
   output logic [tptc_pkg::SCALE_W-1:0]        scale_out,
   output logic                                solvable
);
   import tptc_pkg::*;

   localparam int T   = TOUCH_BITS;
   localparam int S   = SCREEN_BITS;
   localparam int CW  = 2 * T + 1;
   localparam int DW  = 2 * T + 3;
   localparam int NW  = S + 2 * T + 3;
   localparam int PW  = NW + SCALE_W;
   localparam int MX  = (T > S) ? T : S;
   localparam int AW  = ((MX > SCALE_W) ? MX : SCALE_W) + 1;
   localparam int BW  = NW;
   localparam int RW  = $clog2(PW);

   logic [T-1:0]            tx_ff [3];
   logic [T-1:0]            ty_ff [3];
   logic [S-1:0]            sx_ff [3];
   logic [S-1:0]            sy_ff [3];
   logic [SCALE_W-1:0]      scale_ff;
   logic signed [T:0]       dy23_ff, dy13_ff, dy12_ff, dx32_ff, dx13_ff, dx21_ff;
   logic signed [CW-1:0]    cr_ff [3];
   logic signed [DW-1:0]    det_ff;
   logic signed [AW+BW-1:0] prod_ff;
   logic signed [PW-1:0]    acc_ff, acc_in;
   logic signed [AW-1:0]    a_val;
   logic signed [BW-1:0]    b_val;
   logic signed [PW-1:0]    p, pv;
   logic [S-1:0]            w1, w2, w3;
   logic [PW-1:0]           n_ff, n_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           dmag;
   logic [DW:0]             tmp;
   logic [DW+1:0]           sub;
   logic                    ge;
   logic                    sign_ff;
   logic [RW-1:0]           cnt_ff;
   logic [COEF_W-1:0]       sat;
   logic [COEF_W-1:0]       coef_ff [NUM_COEF];
   logic [SCALE_W-1:0]      scale_out_ff;
   logic                    solvable_ff;

   assign w1 = cmd.op.use_y ? sy_ff[0] : sx_ff[0];
   assign w2 = cmd.op.use_y ? sy_ff[1] : sx_ff[1];
   assign w3 = cmd.op.use_y ? sy_ff[2] : sx_ff[2];

   always_comb begin
      unique case (cmd.op.a)
         A_X1:    a_val = AW'($signed({1'b0, tx_ff[0]}));
         A_X2:    a_val = AW'($signed({1'b0, tx_ff[1]}));
         A_X3:    a_val = AW'($signed({1'b0, tx_ff[2]}));
         A_W1:    a_val = AW'($signed({1'b0, w1}));
         A_W2:    a_val = AW'($signed({1'b0, w2}));
         A_W3:    a_val = AW'($signed({1'b0, w3}));
         A_SCALE: a_val = AW'($signed({1'b0, scale_ff}));
         default: a_val = '0;
      endcase
      unique case (cmd.op.b)
         B_DY23:  b_val = BW'(dy23_ff);
         B_DY13:  b_val = BW'(dy13_ff);
         B_DY12:  b_val = BW'(dy12_ff);
         B_DX32:  b_val = BW'(dx32_ff);
         B_DX13:  b_val = BW'(dx13_ff);
         B_DX21:  b_val = BW'(dx21_ff);
         B_Y1:    b_val = BW'($signed({1'b0, ty_ff[0]}));
         B_Y2:    b_val = BW'($signed({1'b0, ty_ff[1]}));
         B_Y3:    b_val = BW'($signed({1'b0, ty_ff[2]}));
         B_CR1:   b_val = BW'(cr_ff[0]);
         B_CR2:   b_val = BW'(cr_ff[1]);
         B_CR3:   b_val = BW'(cr_ff[2]);
         B_ACC:   b_val = $signed(acc_ff[NW-1:0]);
         default: b_val = '0;
      endcase
   end

   assign p      = $signed(prod_ff[PW-1:0]);
   assign pv     = cmd.op.neg ? -p : p;
   assign acc_in = cmd.op.first ? pv : acc_ff + pv;

   // restoring divide on magnitudes, one quotient bit per beat of the step
   assign dmag   = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   assign tmp    = {rem_ff, n_ff[PW-1]};
   assign sub    = {1'b0, tmp} - {2'b00, dmag};
   assign ge     = !sub[DW+1];
   assign rem_in = ge ? sub[DW-1:0] : tmp[DW-1:0];
   assign n_in   = {n_ff[PW-2:0], ge};

   // signed truncated quotient saturated to 32 bits
   always_comb begin
      if (sign_ff) begin
         if ((n_ff[PW-1:COEF_W] != '0) || (n_ff[COEF_W-1] && (n_ff[COEF_W-2:0] != '0))) begin
            sat = {1'b1, {(COEF_W-1){1'b0}}};
         end else begin
            sat = ~n_ff[COEF_W-1:0] + COEF_W'(1);
         end
      end else begin
         if (n_ff[PW-1:COEF_W-1] != '0) begin
            sat = {1'b0, {(COEF_W-1){1'b1}}};
         end else begin
            sat = n_ff[COEF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         tx_ff[cmd.pt_idx] <= in_tx;
         ty_ff[cmd.pt_idx] <= in_ty;
         sx_ff[cmd.pt_idx] <= in_sx;
         sy_ff[cmd.pt_idx] <= in_sy;
      end
      if (cmd.calc_diff) begin
         dy23_ff <= $signed({1'b0, ty_ff[1]}) - $signed({1'b0, ty_ff[2]});
         dy13_ff <= $signed({1'b0, ty_ff[0]}) - $signed({1'b0, ty_ff[2]});
         dy12_ff <= $signed({1'b0, ty_ff[0]}) - $signed({1'b0, ty_ff[1]});
         dx32_ff <= $signed({1'b0, tx_ff[2]}) - $signed({1'b0, tx_ff[1]});
         dx13_ff <= $signed({1'b0, tx_ff[0]}) - $signed({1'b0, tx_ff[2]});
         dx21_ff <= $signed({1'b0, tx_ff[1]}) - $signed({1'b0, tx_ff[0]});
      end
      if (cmd.mul_en) begin
         prod_ff <= a_val * b_val;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
         unique case (cmd.op.dest)
            D_CR1: cr_ff[0] <= acc_in[CW-1:0];
            D_CR2: cr_ff[1] <= acc_in[CW-1:0];
            D_CR3: cr_ff[2] <= acc_in[CW-1:0];
            D_DET: det_ff   <= acc_in[DW-1:0];
            D_NUM: begin
               n_ff    <= acc_in[PW-1] ? PW'(-acc_in) : PW'(acc_in);
               sign_ff <= acc_in[PW-1] ^ det_ff[DW-1];
               rem_ff  <= '0;
               cnt_ff  <= '0;
            end
            default: ;
         endcase
      end
      if (cmd.div_step) begin
         n_ff   <= n_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + RW'(1);
      end
      if (cmd.wb) begin
         coef_ff[cmd.coef_idx] <= sat;
      end
      if (cmd.finish) begin
         solvable_ff  <= (det_ff != '0);
         scale_out_ff <= (det_ff != '0) ? scale_ff : '0;
         if (det_ff == '0) begin
            for (int i = 0; i < NUM_COEF; i++) begin
               coef_ff[i] <= '0;
            end
         end
      end
   end

   assign stat.det_zero = (det_ff == '0);
   assign stat.div_last = (cnt_ff == RW'(PW - 1));
   assign coef          = coef_ff;
   assign scale_out     = scale_out_ff;
   assign solvable      = solvable_ff;

endmodule

// ----- tb/sv/three_point_touch_calibration_chk.sv -----
// ----------------------------------------------------------------------------
// three_point_touch_calibration_chk
// Watches the point, result and register channels of the touch calibrator.
// It keeps its own copy of the point count, the stored points and coef_scale,
// solves each completed set of three points exactly, and compares every
// result beat field by field with the oldest predicted solution.
// ----------------------------------------------------------------------------
module three_point_touch_calibration_chk (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [207:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import tptc_pkg::*;

   typedef struct {
      longint tx, ty, sx, sy;
   } cal_point_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [NUM_COEF-1:0][COEF_W-1:0] coef;
      logic solvable;
   } solution_type;

   cal_point_type       held_points [3];
   int                  point_count;
   logic [SCALE_W-1:0]  scale_reg;
   solution_type        solution_q [$];

   function automatic logic [31:0] sat_quotient(longint num, longint det, longint s);
      longint q, r, v;
      longint lim;
      lim = 64'sd1 <<< 33;
      q = num / det;
      r = num % det;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      v = q * s + (r * s) / det;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic solution_type solve_affine(logic [SCALE_W-1:0] s);
      solution_type sol;
      longint x1, y1, x2, y2, x3, y3, det, w1, w2, w3;
      longint num [6];
      x1 = held_points[0].tx; y1 = held_points[0].ty;
      x2 = held_points[1].tx; y2 = held_points[1].ty;
      x3 = held_points[2].tx; y3 = held_points[2].ty;
      det = x1 * (y2 - y3) - x2 * (y1 - y3) + x3 * (y1 - y2);
      for (int i = 0; i < 2; i++) begin
         w1 = (i == 0) ? held_points[0].sx : held_points[0].sy;
         w2 = (i == 0) ? held_points[1].sx : held_points[1].sy;
         w3 = (i == 0) ? held_points[2].sx : held_points[2].sy;
         num[3*i]   = w1 * (y2 - y3) - w2 * (y1 - y3) + w3 * (y1 - y2);
         num[3*i+1] = w1 * (x3 - x2) + w2 * (x1 - x3) + w3 * (x2 - x1);
         num[3*i+2] = w1 * (x2 * y3 - x3 * y2) - w2 * (x1 * y3 - x3 * y1)
                    + w3 * (x1 * y2 - x2 * y1);
      end
      for (int i = 0; i < NUM_COEF; i++)
         sol.coef[i] = (det != 0) ? sat_quotient(num[i], det, longint'(s)) : '0;
      sol.scale    = (det != 0) ? s : '0;
      sol.solvable = (det != 0);
      return sol;
   endfunction

   assign pending = solution_q.size();

   always @(posedge clock) begin
      solution_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         point_count <= 0;
         scale_reg   <= SCALE_RESET;
         fail_count  <= 0;
         solution_q.delete();
      end else begin
         if (csr_wr_en) scale_reg <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            held_points[point_count].tx = longint'(req_tdata[11:0]);
            held_points[point_count].ty = longint'(req_tdata[23:12]);
            held_points[point_count].sx = longint'(req_tdata[34:24]);
            held_points[point_count].sy = longint'(req_tdata[45:35]);
            if (point_count == 2) begin
               solution_q.push_back(solve_affine(scale_reg));
               point_count <= 0;
            end else begin
               point_count <= point_count + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.coef     = rsp_tdata[191:0];
            got.scale    = rsp_tdata[207:192];
            got.solvable = rsp_tuser;
            if (solution_q.size() == 0) begin
               $display("%0t: unexpected result beat tdata=%h tuser=%b",
                        $time, rsp_tdata, rsp_tuser);
               errs++;
            end else begin
               want = solution_q.pop_front();
               for (int i = 0; i < NUM_COEF; i++)
                  if (got.coef[i] !== want.coef[i]) begin
                     $display("%0t: coef %0d expected %0d actual %0d", $time, i,
                              $signed(want.coef[i]), $signed(got.coef[i]));
                     errs++;
                  end
               if (got.scale !== want.scale) begin
                  $display("%0t: scale_out expected %0d actual %0d",
                           $time, want.scale, got.scale);
                  errs++;
               end
               if (got.solvable !== want.solvable) begin
                  $display("%0t: solvable expected %b actual %b",
                           $time, want.solvable, got.solvable);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// ----- tb/sv/three_point_touch_calibration_tb.sv -----
// ----------------------------------------------------------------------------
// three_point_touch_calibration_tb
// Feeds calibration point triples to the touch calibrator under several
// coef_scale settings: directed extremes, collinear and overflowing sets,
// then random triples, with random stalls on both channels. A separate
// checker predicts and compares the coefficient beats.
// ----------------------------------------------------------------------------
module three_point_touch_calibration_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tptc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SOLVE_CYCLES = 500;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;
   int           fail_count;
   int           pending;
   int           cycle_count;
   bit           quiet;

   three_point_touch_calibration dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   three_point_touch_calibration_chk chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // result side stalls
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_point(logic [11:0] tx, logic [11:0] ty,
                             logic [10:0] sx, logic [10:0] sy);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sy, sx, ty, tx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic set_scale(logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SOLVE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_triple();
      logic [11:0] tx [3];
      logic [11:0] ty [3];
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         tx[i] = 12'($urandom_range(0, 4095));
         ty[i] = 12'($urandom_range(0, 4095));
      end
      if (kind == 0) begin
         // collinear set along a line through the first point
         tx[1] = tx[0]; tx[2] = tx[0];
      end else if (kind == 1) begin
         // nearly collinear, tiny determinant
         tx[1] = tx[0] + 12'd1; ty[1] = ty[0];
         tx[2] = tx[0]; ty[2] = ty[0] + 12'd1;
      end
      for (int i = 0; i < 3; i++)
         send_point(tx[i], ty[i], 11'($urandom_range(0, 2047)),
                    11'($urandom_range(0, 2047)));
   endtask

   initial begin
      logic [15:0] scales [6];
      quiet       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset scale
      send_point(12'd0, 12'd0, 11'd0, 11'd0);
      send_point(12'd4095, 12'd0, 11'd2047, 11'd0);
      send_point(12'd0, 12'd4095, 11'd0, 11'd2047);
      send_point(12'd100, 12'd100, 11'd5, 11'd5);
      send_point(12'd100, 12'd100, 11'd7, 11'd9);
      send_point(12'd100, 12'd100, 11'd2047, 11'd2047);
      set_scale(16'd65535);
      send_point(12'd4095, 12'd4095, 11'd2047, 11'd2047);
      send_point(12'd4094, 12'd4095, 11'd0, 11'd0);
      send_point(12'd4095, 12'd4094, 11'd0, 11'd0);
      send_point(12'd0, 12'd0, 11'd2047, 11'd0);
      send_point(12'd1, 12'd0, 11'd0, 11'd2047);
      send_point(12'd0, 12'd1, 11'd0, 11'd0);
      set_scale(16'd1);
      send_point(12'd4095, 12'd0, 11'd2047, 11'd2047);
      send_point(12'd0, 12'd4095, 11'd0, 11'd0);
      send_point(12'd2048, 12'd2048, 11'd1024, 11'd1024);
      set_scale(16'd0);
      send_point(12'd10, 12'd20, 11'd30, 11'd40);
      send_point(12'd300, 12'd20, 11'd600, 11'd40);
      send_point(12'd10, 12'd900, 11'd30, 11'd1800);
      send_point(12'd5, 12'd5, 11'd1, 11'd1);
      send_point(12'd5, 12'd5, 11'd2, 11'd2);
      send_point(12'd5, 12'd5, 11'd3, 11'd3);

      // random sets under several scales
      scales = '{16'd10000, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd0};
      scales[4] = 16'($urandom_range(1, 65535));
      scales[5] = 16'($urandom_range(1, 65535));
      for (int p = 0; p < 6; p++) begin
         set_scale(scales[p]);
         if (p == 5) quiet = 1'b1;
         repeat (p == 3 ? 10 : 48) random_triple();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SOLVE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
